// ===== design/fqwr_pkg.sv =====
// ----------------------------------------------------------------------------
// fqwr_pkg
// Shared sizes, codes, index and port conversion helpers of the fifo queue with remove.
// ----------------------------------------------------------------------------
package fqwr_pkg;

   localparam int DEPTH       = 16;
   localparam int HANDLE_BITS = 16;

   // fixed widths of the stream fields
   localparam int PORT_HANDLE_BITS = 16;
   localparam int PORT_COUNT_BITS  = 5;
   localparam int FUNC_BITS        = 2;
   localparam int STATUS_BITS      = 3;

   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = CNT_BITS + 1;

   localparam int COMMON_HANDLE_BITS =
      (HANDLE_BITS < PORT_HANDLE_BITS) ? HANDLE_BITS : PORT_HANDLE_BITS;
   localparam int COMMON_COUNT_BITS  =
      (CNT_BITS < PORT_COUNT_BITS) ? CNT_BITS : PORT_COUNT_BITS;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ENQ = 2'd0,
      FUNC_DEQ = 2'd1,
      FUNC_REM = 2'd2,
      FUNC_NOP = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK       = 3'd0,
      STAT_NULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ,
      S_SRCH,
      S_SH_RD,
      S_SH_WR
   } state_type;

   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;

   // physical slot of the entry at a given offset from the head
   function automatic idx_type slot_of(input idx_type head, input cnt_type off);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(head) + SUM_BITS'(off);
      if (s >= SUM_BITS'(DEPTH)) begin
         s = s - SUM_BITS'(DEPTH);
      end
      return s[IDX_BITS-1:0];
   endfunction

   function automatic handle_type from_port_handle(input logic [PORT_HANDLE_BITS-1:0] h);
      handle_type r;
      r = '0;
      r[COMMON_HANDLE_BITS-1:0] = h[COMMON_HANDLE_BITS-1:0];
      return r;
   endfunction

   function automatic logic [PORT_HANDLE_BITS-1:0] to_port_handle(input handle_type h);
      logic [PORT_HANDLE_BITS-1:0] r;
      r = '0;
      r[COMMON_HANDLE_BITS-1:0] = h[COMMON_HANDLE_BITS-1:0];
      return r;
   endfunction

   function automatic logic [PORT_COUNT_BITS-1:0] to_port_count(input cnt_type c);
      logic [PORT_COUNT_BITS-1:0] r;
      r = '0;
      r[COMMON_COUNT_BITS-1:0] = c[COMMON_COUNT_BITS-1:0];
      return r;
   endfunction

endpackage

// ===== design/fifo_queue_with_remove_core.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_core
// Bounded ordered queue of nonzero handles with enqueue, dequeue and remove.
// ----------------------------------------------------------------------------
// Each request beat carries an operation and a handle; each one yields exactly
// one response beat with the dequeued handle, a status, the entry count and an
// empty flag. Entries sit in a circular store with one write port and one
// registered read port that is read at one slot per cycle, and a small
// sequencer steps one shared index counter and comparator through it. Enqueue,
// no-op and every rejected request are answered straight from the idle state;
// a dequeue passes through S_DEQ to take the head entry from the read register.
// A remove walks S_SRCH from the head to the match, then closes the gap with
// one read (S_SH_RD) and one write (S_SH_WR) per later entry; a miss walks
// every entry. The slowest case is a match at the head of a full queue. A new
// request is taken only in S_IDLE, once the response register is free or is being drained.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_core
   import fqwr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] item_handle
   input  logic [1:0]  req_tuser,   // [1:0] func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] out_handle, [20:16] entry_count,
                                    // [21] is_empty, [23:22] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   state_type  state_ff, state_in;
   idx_type    head_ff, head_in;
   cnt_type    count_ff, count_in;
   cnt_type    idx_ff, idx_in;
   handle_type handle_ff, handle_in;

   handle_type entry_store_ff [DEPTH];
   handle_type rd_data_ff;
   idx_type    rd_idx, wr_idx;
   handle_type wr_data;
   logic       mem_we;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [PORT_HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic [PORT_COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                        rsp_empty_ff, rsp_empty_in;

   logic       accept;
   func_type   req_func;
   handle_type req_handle;
   logic       req_null, q_full, q_zero;
   cnt_type    idx_next;
   logic       hit, walk_last, shift_more;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign req_func   = func_type'(req_tuser);
   assign req_handle = from_port_handle(req_tdata);
   assign req_null   = (req_handle == '0);
   assign q_full     = (count_ff == CNT_BITS'(DEPTH));
   assign q_zero     = (count_ff == '0);

   // shared index step and compare
   assign idx_next   = idx_ff + 1'b1;
   assign hit        = (rd_data_ff == handle_ff);
   assign walk_last  = (idx_next >= count_ff);
   assign shift_more = (idx_next < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_DEQ: if (!q_zero) state_in = S_DEQ;
                  FUNC_REM: if (!req_null && !q_zero) state_in = S_SRCH;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_DEQ:   state_in = S_IDLE;
         S_SRCH: begin
            if (hit) begin
               state_in = S_SH_RD;
            end else if (walk_last) begin
               state_in = S_IDLE;
            end
         end
         S_SH_RD: state_in = shift_more ? S_SH_WR : S_IDLE;
         S_SH_WR: state_in = S_SH_RD;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      logic       done;
      status_type done_status;
      handle_type done_handle;

      done        = 1'b0;
      done_status = STAT_OK;
      done_handle = '0;

      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      handle_in = handle_ff;
      mem_we    = 1'b0;
      rd_idx    = head_ff;
      wr_idx    = slot_of(head_ff, count_ff);
      wr_data   = req_handle;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               handle_in = req_handle;
               idx_in    = '0;
               unique case (req_func)
                  FUNC_ENQ: begin
                     done = 1'b1;
                     if (req_null) begin
                        done_status = STAT_NULL;
                     end else if (q_full) begin
                        done_status = STAT_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_DEQ: begin
                     if (q_zero) begin
                        done        = 1'b1;
                        done_status = STAT_EMPTY;
                     end
                  end
                  FUNC_REM: begin
                     if (req_null) begin
                        done        = 1'b1;
                        done_status = STAT_NULL;
                     end else if (q_zero) begin
                        done        = 1'b1;
                        done_status = STAT_NOTFOUND;
                     end
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         S_DEQ: begin
            done        = 1'b1;
            done_handle = rd_data_ff;
            head_in     = slot_of(head_ff, CNT_BITS'(1));
            count_in    = count_ff - 1'b1;
         end
         S_SRCH: begin
            if (!hit) begin
               if (walk_last) begin
                  done        = 1'b1;
                  done_status = STAT_NOTFOUND;
               end else begin
                  idx_in = idx_next;
                  rd_idx = slot_of(head_ff, idx_next);
               end
            end
         end
         S_SH_RD: begin
            if (shift_more) begin
               rd_idx = slot_of(head_ff, idx_next);
            end else begin
               done     = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         S_SH_WR: begin
            // move the later entry one slot toward the head
            mem_we  = 1'b1;
            wr_idx  = slot_of(head_ff, idx_ff);
            wr_data = rd_data_ff;
            idx_in  = idx_next;
         end
         default: ;
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = to_port_handle(done_handle);
         rsp_status_in = done_status;
         rsp_count_in  = to_port_count(count_in);
         rsp_empty_in  = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      handle_ff     <= handle_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // entry store with one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_idx];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_empty_ff, rsp_count_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fifo queue with remove.
// ----------------------------------------------------------------------------
// Request beats come from a queue that the stimulus block fills: first a
// directed run over the empty, null, no-op, full and duplicate cases, and
// then about a thousand random operations. The random part swings between
// fill-heavy, drain-heavy and mixed phases. Removes mostly aim at handles that
// are known to be queued. Every accepted request is run through a queue model
// kept in the bench, and each response beat is checked field by field against
// the oldest predicted response. Both sides idle at random, except for one
// calm stretch.
// ----------------------------------------------------------------------------
module testbench;
   import fqwr_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      logic [15:0] out_handle;
      status_type  status;
      logic [4:0]  entry_count;
      logic        is_empty;
   } queue_result_type;

   typedef struct {
      func_type    func;
      logic [15:0] handle;
   } queue_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] item_handle
   logic [1:0]  req_tuser  = '0;   // [1:0] func

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] out_handle, [20:16] entry_count,
                                   // [21] is_empty, [23:22] zero
   logic [2:0]  rsp_tuser;         // [2:0] status

   handle_type        model_entries[$];
   handle_type        plan_entries[$];
   queue_request_type pending_reqs[$];
   queue_result_type  expected_rsps[$];
   queue_request_type next_req;
   queue_result_type  want_rsp;

   int   error_count = 0;
   int   req_count   = 0;
   int   rsp_count   = 0;
   int   stall_cycles = 0;
   int   status_hist[5] = '{0, 0, 0, 0, 0};
   logic calm = 1'b0;

   fifo_queue_with_remove_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // applies one operation to an ordered list of handles, returns the response
   function automatic queue_result_type queue_step(ref handle_type entries[$],
                                                   input func_type f,
                                                   input handle_type h);
      queue_result_type r;
      int               i;
      r.out_handle = '0;
      r.status     = STAT_OK;
      case (f)
         FUNC_ENQ: begin
            if (h == '0) r.status = STAT_NULL;
            else if (entries.size() >= DEPTH) r.status = STAT_FULL;
            else entries.push_back(h);
         end
         FUNC_DEQ: begin
            if (entries.size() == 0) r.status = STAT_EMPTY;
            else r.out_handle = entries.pop_front();
         end
         FUNC_REM: begin
            if (h == '0) begin
               r.status = STAT_NULL;
            end else begin
               r.status = STAT_NOTFOUND;
               for (i = 0; i < entries.size(); i++) begin
                  if (entries[i] == h) begin
                     entries.delete(i);
                     r.status = STAT_OK;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      r.entry_count = 5'(entries.size());
      r.is_empty    = (entries.size() == 0);
      return r;
   endfunction

   task automatic add_request(input func_type f, input logic [15:0] h);
      queue_request_type q;
      queue_result_type  unused;
      q.func   = f;
      q.handle = h;
      pending_reqs.push_back(q);
      // track contents so removes can aim at queued handles
      unused = queue_step(plan_entries, f, h);
   endtask

   task automatic add_random_requests(input int n);
      int          i;
      int          r;
      int          enq_pct;
      int          deq_pct;
      func_type    f;
      logic [15:0] h;
      for (i = 0; i < n; i++) begin
         case ((i / 80) % 3)
            0:       begin enq_pct = 65; deq_pct = 15; end
            1:       begin enq_pct = 20; deq_pct = 55; end
            default: begin enq_pct = 35; deq_pct = 30; end
         endcase
         r = $urandom_range(99);
         if (r < enq_pct) f = FUNC_ENQ;
         else if (r < enq_pct + deq_pct) f = FUNC_DEQ;
         else if (r < 95) f = FUNC_REM;
         else f = FUNC_NOP;
         r = $urandom_range(99);
         if (r < 5) h = '0;
         else if (r < 25) h = 16'($urandom_range(65535));
         else h = 16'($urandom_range(12, 1));
         if (f == FUNC_REM && plan_entries.size() > 0 && $urandom_range(99) < 60) begin
            h = plan_entries[$urandom_range(plan_entries.size() - 1)];
         end
         add_request(f, h);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 40) begin
         $display("testbench: beat %0d %s: got %0h, want %0h", rsp_count, what, got, want);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         calm       <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(queue_step(model_entries, func_type'(req_tuser),
                                               req_tdata));
            req_count++;
         end
         calm <= (req_count >= 400 && req_count < 550);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
               next_req   = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_req.handle;
               req_tuser  <= next_req.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("beat with nothing expected", 32'(rsp_tdata), 32'd0);
            end else begin
               want_rsp = expected_rsps.pop_front();
               status_hist[int'(want_rsp.status)]++;
               if (rsp_tdata[15:0] !== want_rsp.out_handle)
                  report_mismatch("out_handle", 32'(rsp_tdata[15:0]),
                                  32'(want_rsp.out_handle));
               if (rsp_tuser !== want_rsp.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want_rsp.status));
               if (rsp_tdata[20:16] !== want_rsp.entry_count)
                  report_mismatch("entry_count", 32'(rsp_tdata[20:16]),
                                  32'(want_rsp.entry_count));
               if (rsp_tdata[21] !== want_rsp.is_empty)
                  report_mismatch("is_empty", 32'(rsp_tdata[21]), 32'(want_rsp.is_empty));
               if (rsp_tdata[23:22] !== 2'b00)
                  report_mismatch("pad bits", 32'(rsp_tdata[23:22]), 32'd0);
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 29);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: no beat moved for %0d cycles, %0d responses outstanding",
                  stall_cycles, expected_rsps.size());
         $display("testbench: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty queue, null handles, unused code
      add_request(FUNC_DEQ, 16'hFFFF);
      add_request(FUNC_REM, 16'h0007);
      add_request(FUNC_ENQ, 16'h0000);
      add_request(FUNC_REM, 16'h0000);
      add_request(FUNC_NOP, 16'hFFFF);
      // fill to capacity with a duplicate at the tail
      add_request(FUNC_ENQ, 16'hFFFF);
      add_request(FUNC_ENQ, 16'h0001);
      for (k = 2; k <= 14; k++) add_request(FUNC_ENQ, 16'(k * 16'h1111));
      add_request(FUNC_ENQ, 16'h0001);
      add_request(FUNC_ENQ, 16'h8000);   // dropped, queue full
      add_request(FUNC_REM, 16'h1234);   // miss on a full queue
      add_request(FUNC_REM, 16'h0001);   // first of the two copies goes
      add_request(FUNC_DEQ, 16'hAAAA);

      // hold off until the directed part has fully answered
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);

      add_random_requests(RANDOM_ITEMS);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("testbench: %0d requests, %0d responses; ok %0d, null %0d, empty %0d",
               req_count, rsp_count, status_hist[int'(STAT_OK)],
               status_hist[int'(STAT_NULL)], status_hist[int'(STAT_EMPTY)]);
      $display("testbench: full drops %0d, remove misses %0d, mismatches %0d",
               status_hist[int'(STAT_FULL)], status_hist[int'(STAT_NOTFOUND)],
               error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
